// ===== sv/thlfr_pkg.sv =====
`timescale 1ns / 1ps
package thlfr_pkg;

  localparam int BUFFER_BYTES_DEF = 64;
  localparam int HDR_BYTES        = 3;
  localparam int POS_W            = 9;

  localparam logic [7:0] HDR1_RESET = 8'hAA;
  localparam logic [7:0] HDR2_RESET = 8'h55;

  typedef enum logic [1:0] {
    FN_BYTE  = 2'd0,
    FN_CLEAR = 2'd1,
    FN_READ  = 2'd2
  } func_t;

  typedef enum logic [0:0] {
    CFG_HDR1 = 1'b0,
    CFG_HDR2 = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_HEAD1 = 4'b0001,
    PH_HEAD2 = 4'b0010,
    PH_LEN   = 4'b0100,
    PH_BODY  = 4'b1000
  } phase_t;

  localparam logic [1:0] PH_CODE_HEAD1 = 2'd0;
  localparam logic [1:0] PH_CODE_HEAD2 = 2'd1;
  localparam logic [1:0] PH_CODE_LEN   = 2'd2;
  localparam logic [1:0] PH_CODE_BODY  = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic       frame_ready;
    logic [6:0] frame_length;
    logic [7:0] read_data;
    logic [1:0] parser_phase;
  } out_item_t;

  typedef struct packed {
    logic       frame_ready;
    logic [6:0] frame_length;
    logic [1:0] parser_phase;
  } status_t;

endpackage

// ===== sv/thlfr_ram.sv =====
`timescale 1ns / 1ps
module thlfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/thlfr_parser.sv =====
`timescale 1ns / 1ps
module thlfr_parser import thlfr_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int AW = $clog2(BUFFER_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  in_item_t      item,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [7:0]    cfg_wdata,
  output status_t       status,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  logic [7:0] hdr1_r, hdr2_r;
  phase_t     phase_r, phase_nxt;
  logic       ready_r, ready_nxt;
  logic [7:0] blen_r, blen_nxt;
  logic [7:0] bcount_r, bcount_nxt;
  logic [6:0] clen_r, clen_nxt;

  logic [POS_W-1:0] body_pos;
  logic [POS_W-1:0] total_len;
  logic [7:0]       count_inc;

  assign body_pos  = POS_W'(HDR_BYTES) + POS_W'(bcount_r);
  assign total_len = POS_W'(HDR_BYTES) + POS_W'(blen_r);
  assign count_inc = bcount_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr1_r   <= HDR1_RESET;
      hdr2_r   <= HDR2_RESET;
      phase_r  <= PH_HEAD1;
      ready_r  <= 1'b0;
      blen_r   <= '0;
      bcount_r <= '0;
      clen_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HDR1: hdr1_r <= cfg_wdata;
          CFG_HDR2: hdr2_r <= cfg_wdata;
          default: ;
        endcase
      end
      phase_r  <= phase_nxt;
      ready_r  <= ready_nxt;
      blen_r   <= blen_nxt;
      bcount_r <= bcount_nxt;
      clen_r   <= clen_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    ready_nxt  = ready_r;
    blen_nxt   = blen_r;
    bcount_nxt = bcount_r;
    clen_nxt   = clen_r;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = item.rx_byte;
    if (step) begin
      unique case (item.func)
        FN_BYTE: begin
          if (!ready_r) begin
            unique case (phase_r)
              PH_HEAD1: begin
                if (item.rx_byte == hdr1_r) begin
                  wr_en     = 1'b1;
                  wr_addr   = AW'(0);
                  phase_nxt = PH_HEAD2;
                end
              end
              PH_HEAD2: begin
                if (item.rx_byte == hdr2_r) begin
                  wr_en     = 1'b1;
                  wr_addr   = AW'(1);
                  phase_nxt = PH_LEN;
                end else begin
                  phase_nxt = PH_HEAD1;
                end
              end
              PH_LEN: begin
                blen_nxt = item.rx_byte;
                wr_en    = 1'b1;
                wr_addr  = AW'(2);
                if (POS_W'(item.rx_byte) > POS_W'(BUFFER_BYTES - HDR_BYTES)) begin
                  phase_nxt = PH_HEAD1;
                end else begin
                  bcount_nxt = '0;
                  phase_nxt  = PH_BODY;
                end
              end
              PH_BODY: begin
                wr_en      = (body_pos < POS_W'(BUFFER_BYTES));
                wr_addr    = body_pos[AW-1:0];
                bcount_nxt = count_inc;
                if (count_inc >= blen_r) begin
                  clen_nxt  = total_len[6:0];
                  ready_nxt = 1'b1;
                  phase_nxt = PH_HEAD1;
                end
              end
              default: phase_nxt = PH_HEAD1;
            endcase
          end
        end
        FN_CLEAR: ready_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    status.frame_ready  = ready_nxt;
    status.frame_length = clen_nxt;
    unique case (phase_nxt)
      PH_HEAD1: status.parser_phase = PH_CODE_HEAD1;
      PH_HEAD2: status.parser_phase = PH_CODE_HEAD2;
      PH_LEN:   status.parser_phase = PH_CODE_LEN;
      PH_BODY:  status.parser_phase = PH_CODE_BODY;
      default:  status.parser_phase = PH_CODE_HEAD1;
    endcase
  end

endmodule

// ===== sv/two_byte_header_length_frame_receiver.sv =====
`timescale 1ns / 1ps
// Frame receiver for header1, header2, length, body byte streams. One item is
// accepted every clock cycle while in_stall is low; each gives one result beat
// through the registered read of the single frame buffer memory (one write
// port for stored bytes, one read port for read items) and then through the
// output register. in_stall rises only when the memory read stage and the output
// register are both full and the output is stalled. The frame buffer
// has no reset; reading an entry not yet written returns arbitrary data.
module two_byte_header_length_frame_receiver import thlfr_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int AW = $clog2(BUFFER_BYTES);

  logic          in_acc;
  logic          s1_adv;
  logic          s1_valid_r;
  status_t       s1_stat_r;
  logic          s1_read_r;
  status_t       stat;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    rd_data;
  logic [POS_W-1:0] idx_ext;
  logic          rd_hit;
  logic          out_valid_r;
  out_item_t     out_item_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign idx_ext = POS_W'(in_item.read_index);
  assign rd_hit  = (in_item.func == FN_READ) && (idx_ext < POS_W'(BUFFER_BYTES));

  thlfr_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_acc),
    .item     (in_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .status   (stat),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  thlfr_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (in_acc && rd_hit),
    .raddr(idx_ext[AW-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_stat_r <= stat;
      s1_read_r <= rd_hit;
    end
    if (s1_adv) begin
      out_item_r.frame_ready  <= s1_stat_r.frame_ready;
      out_item_r.frame_length <= s1_stat_r.frame_length;
      out_item_r.parser_phase <= s1_stat_r.parser_phase;
      out_item_r.read_data    <= s1_read_r ? rd_data : 8'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
